FILE: rtl/core/worst_fit_heap_allocator_unit_macros.svh
// Assertion macros for the worst-fit heap allocator.
`ifndef WORST_FIT_HEAP_ALLOCATOR_UNIT_MACROS_SVH
`define WORST_FIT_HEAP_ALLOCATOR_UNIT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define WFH_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// Next-cycle implication checked outside reset.
`define WFH_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`endif

FILE: rtl/core/wfha_pkg.sv
// Shared types and constants for the worst-fit heap allocator.
package wfha_pkg;
   localparam int HEAP_BYTES = 1024;

   localparam logic [1:0] ST_DONE    = 2'd0;
   localparam logic [1:0] ST_NOFIT   = 2'd1;
   localparam logic [1:0] ST_IGNORED = 2'd2;
   localparam logic       KIND_ALLOC = 1'b0;
   localparam logic       KIND_FREE  = 1'b1;

   typedef enum logic [3:0] {
      OP_NONE, OP_CLEAR, OP_SCAN_RD, OP_SCAN_CMP, OP_ALLOC_WR, OP_SPLIT_WR,
      OP_SPLIT_NXT_RD, OP_SPLIT_NXT_WR, OP_FREE_RD, OP_FREE_NXT_RD, OP_FREE_NXT_WR,
      OP_FREE_PRV_RD, OP_FREE_PRV_WR, OP_FREE_LINK_RD, OP_FREE_LINK_WR
   } op_type;

   typedef struct packed {
      op_type op;
   } cmd_type;

   typedef struct packed {
      logic clear_last;
      logic scan_last;
      logic found;
      logic is_start;
      logic nxt_free;
      logic prv_free;
      logic has_link;
      logic has_rest;
      logic cur_nz;
   } sts_type;
endpackage

FILE: rtl/core/wfha_datapath.sv
// Segment table memories and arithmetic of the worst-fit heap allocator.
`include "worst_fit_heap_allocator_unit_macros.svh"
module wfha_datapath (
   input  logic             clock,
   input  logic             reset,
   input  wfha_pkg::cmd_type cmd,
   input  logic [10:0]      req_alloc_size,
   input  logic [9:0]       req_free_index,
   output wfha_pkg::sts_type sts,
   output logic [9:0]       best_index
);
   localparam int HEAP_BYTES = wfha_pkg::HEAP_BYTES;
   localparam int AW = $clog2(HEAP_BYTES);
   localparam int LW = AW + 1;
   // entry word: start mark, used mark, length
   localparam int EW = LW + 2;
   localparam logic [LW-1:0] HeapLen = LW'(HEAP_BYTES);

   logic [EW-1:0] seg_mem [HEAP_BYTES];
   logic [AW-1:0] prev_mem [HEAP_BYTES];

   logic [EW-1:0] rd_ff;
   logic [AW-1:0] prv_rd_ff;
   logic [AW:0]   cnt_ff, cnt_in;
   logic [AW-1:0] best_ff, best_in;
   logic [LW-1:0] best_len_ff, best_len_in;
   logic          found_ff, found_in;
   logic [AW-1:0] cur_ff, cur_in;       // segment being freed / merged base
   logic [LW-1:0] cur_len_ff, cur_len_in;
   logic [AW:0]   nxt_ff, nxt_in;       // successor address, may reach HEAP_BYTES
   logic [LW-1:0] size_ff, size_in;

   logic          wr_en, pwr_en;
   logic [AW-1:0] wr_addr, rd_addr, pwr_addr, prd_addr;
   logic [EW-1:0] wr_data;
   logic [AW-1:0] pwr_data;

   wire           r_mark = rd_ff[EW-1];
   wire           r_used = rd_ff[EW-2];
   wire [LW-1:0]  r_len  = rd_ff[LW-1:0];
   logic [LW:0]   sum_nxt;

   always_comb begin
      cnt_in = cnt_ff; best_in = best_ff; best_len_in = best_len_ff; found_in = found_ff;
      cur_in = cur_ff; cur_len_in = cur_len_ff; nxt_in = nxt_ff; size_in = size_ff;
      wr_en = 1'b0; pwr_en = 1'b0; wr_addr = cnt_ff[AW-1:0]; wr_data = '0;
      pwr_addr = '0; pwr_data = cur_ff; rd_addr = cnt_ff[AW-1:0];
      prd_addr = cur_ff;
      sum_nxt = {1'b0, cur_ff} + {1'b0, r_len};
      unique case (cmd.op)
         wfha_pkg::OP_CLEAR: begin
            wr_en = 1'b1;
            wr_data = (cnt_ff == '0) ? {2'b10, HeapLen} : '0;
            cnt_in = cnt_ff + 1'b1;
         end
         wfha_pkg::OP_SCAN_RD: begin
            cnt_in = '0; found_in = 1'b0; best_in = '0; best_len_in = '0;
            size_in = LW'(req_alloc_size);
            rd_addr = '0;
         end
         wfha_pkg::OP_SCAN_CMP: begin
            // rd_ff holds entry cnt_ff; fetch next
            rd_addr = AW'(cnt_ff + 1'b1);
            if (r_mark && !r_used && size_ff <= r_len && (!found_ff || r_len > best_len_ff))
            begin
               found_in = 1'b1; best_in = cnt_ff[AW-1:0]; best_len_in = r_len;
            end
            cnt_in = cnt_ff + 1'b1;
         end
         wfha_pkg::OP_ALLOC_WR: begin
            wr_en = 1'b1; wr_addr = best_ff; wr_data = {2'b11, size_ff};
            nxt_in = {1'b0, best_ff} + {1'b0, size_ff[AW-1:0]} +
                     (size_ff[AW] ? (AW+1)'(HEAP_BYTES) : '0);
         end
         wfha_pkg::OP_SPLIT_WR: begin
            // remainder segment
            wr_en = 1'b1; wr_addr = nxt_ff[AW-1:0];
            wr_data = {2'b10, best_len_ff - size_ff};
            pwr_en = 1'b1; pwr_addr = nxt_ff[AW-1:0]; pwr_data = best_ff;
            cur_in = nxt_ff[AW-1:0]; cur_len_in = best_len_ff - size_ff;
            rd_addr = '0;
            nxt_in = {1'b0, nxt_ff[AW-1:0]} + {1'b0, cur_len_in[AW-1:0]} +
                     (cur_len_in[AW] ? (AW+1)'(HEAP_BYTES) : '0);
         end
         wfha_pkg::OP_SPLIT_NXT_RD: begin
            rd_addr = nxt_ff[AW-1:0];
         end
         wfha_pkg::OP_SPLIT_NXT_WR: begin
            pwr_en = 1'b1; pwr_addr = nxt_ff[AW-1:0]; pwr_data = cur_ff;
         end
         wfha_pkg::OP_FREE_RD: begin
            cur_in = req_free_index[AW-1:0];
            rd_addr = req_free_index[AW-1:0];
            prd_addr = req_free_index[AW-1:0];
         end
         wfha_pkg::OP_FREE_NXT_RD: begin
            cur_len_in = r_len;
            wr_en = 1'b1; wr_addr = cur_ff; wr_data = {2'b10, r_len};
            nxt_in = sum_nxt[AW:0];
            rd_addr = sum_nxt[AW-1:0];
         end
         wfha_pkg::OP_FREE_NXT_WR: begin
            // merge free successor into cur
            cur_len_in = cur_len_ff + r_len;
            wr_en = 1'b1; wr_addr = nxt_ff[AW-1:0]; wr_data = '0;
         end
         wfha_pkg::OP_FREE_PRV_RD: begin
            wr_en = 1'b1; wr_addr = cur_ff; wr_data = {2'b10, cur_len_ff};
            rd_addr = prv_rd_ff;
            nxt_in = {1'b0, prv_rd_ff};
         end
         wfha_pkg::OP_FREE_PRV_WR: begin
            // merge cur into predecessor
            cur_len_in = r_len + cur_len_ff;
            wr_en = 1'b1; wr_addr = cur_ff; wr_data = '0;
            cur_in = nxt_ff[AW-1:0];
         end
         wfha_pkg::OP_FREE_LINK_RD: begin
            wr_en = 1'b1; wr_addr = cur_ff; wr_data = {2'b10, cur_len_ff};
            nxt_in = {1'b0, cur_ff} + {1'b0, cur_len_ff[AW-1:0]} +
                     (cur_len_ff[AW] ? (AW+1)'(HEAP_BYTES) : '0);
            rd_addr = nxt_in[AW-1:0];
         end
         wfha_pkg::OP_FREE_LINK_WR: begin
            pwr_en = 1'b1; pwr_addr = nxt_ff[AW-1:0]; pwr_data = cur_ff;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) seg_mem[wr_addr] <= wr_data;
      if (pwr_en) prev_mem[pwr_addr] <= pwr_data;
      rd_ff <= seg_mem[rd_addr];
      prv_rd_ff <= prev_mem[prd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         found_ff <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         found_ff <= found_in;
      end
      best_ff <= best_in; best_len_ff <= best_len_in; cur_ff <= cur_in;
      cur_len_ff <= cur_len_in; nxt_ff <= nxt_in; size_ff <= size_in;
   end

   wire nxt_in_heap = (nxt_ff < (AW+1)'(HEAP_BYTES));
   always_comb begin
      sts.clear_last = (cnt_ff == (AW+1)'(HEAP_BYTES - 1));
      sts.scan_last  = (cnt_ff == (AW+1)'(HEAP_BYTES - 1));
      sts.found      = found_ff;
      sts.is_start   = r_mark;
      sts.nxt_free   = nxt_in_heap && r_mark && !r_used;
      sts.prv_free   = r_mark && !r_used;
      sts.has_link   = nxt_in_heap && r_mark;
      sts.has_rest   = (best_len_ff > size_ff);
      sts.cur_nz     = (cur_ff != '0);
   end
   assign best_index = 10'(best_ff);

   `WFH_ASSERT_IMPL(a_best_fits, clock, reset,
      found_ff && cmd.op == wfha_pkg::OP_ALLOC_WR, best_len_ff >= size_ff,
      "chosen segment smaller than request")
   `WFH_ASSERT_NEXT(a_scan_count, clock, reset,
      cmd.op == wfha_pkg::OP_SCAN_CMP, cnt_ff == $past(cnt_ff) + 1'b1,
      "scan counter did not advance")
   `WFH_ASSERT_IMPL(a_split_len, clock, reset,
      cmd.op == wfha_pkg::OP_SPLIT_WR, best_len_ff > size_ff,
      "split without remainder")
endmodule

FILE: rtl/core/wfha_ctrl.sv
// Sequencing controller for the worst-fit heap allocator.
`include "worst_fit_heap_allocator_unit_macros.svh"
module wfha_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  logic             req_kind,
   input  logic [10:0]      req_alloc_size,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic [1:0]       rsp_status,
   output logic [9:0]       rsp_start_index,
   input  logic [9:0]       best_index,
   input  wfha_pkg::sts_type sts,
   output wfha_pkg::cmd_type cmd
);
   localparam logic [3:0] S_CLEAR = 4'd0, S_IDLE = 4'd1, S_SCAN = 4'd2, S_ALLOC = 4'd3,
      S_SPLIT = 4'd4, S_SNRD = 4'd5, S_SNWR = 4'd6, S_FRD = 4'd7, S_FNXT = 4'd8,
      S_FNWR = 4'd9, S_FPRD = 4'd10, S_FPWR = 4'd11, S_FLRD = 4'd12, S_FLWR = 4'd13,
      S_FCHK = 4'd14, S_FDONE = 4'd15;

   logic [3:0] state_ff, state_in;
   logic       rv_ff, rv_in;
   logic [1:0] st_ff, st_in;
   logic [9:0] si_ff, si_in;
   logic       fp_ff, fp_in;   // predecessor merge pending
   logic       fnz_ff, fnz_in; // freed index nonzero
   logic       req_take;

   assign req_stall = (state_ff != S_IDLE) || rv_ff;
   assign req_take  = req_valid && !req_stall;
   assign rsp_valid = rv_ff;
   assign rsp_status = st_ff;
   assign rsp_start_index = si_ff;

   always_comb begin
      state_in = state_ff; rv_in = rv_ff; st_in = st_ff; si_in = si_ff;
      fp_in = fp_ff; fnz_in = fnz_ff;
      cmd.op = wfha_pkg::OP_NONE;
      if (rv_ff && !rsp_stall) rv_in = 1'b0;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.op = wfha_pkg::OP_CLEAR;
            if (sts.clear_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_take) begin
               if (req_kind == wfha_pkg::KIND_ALLOC) begin
                  if (req_alloc_size == '0) begin
                     rv_in = 1'b1; st_in = wfha_pkg::ST_NOFIT; si_in = '0;
                  end else begin
                     cmd.op = wfha_pkg::OP_SCAN_RD; state_in = S_SCAN;
                  end
               end else begin
                  cmd.op = wfha_pkg::OP_FREE_RD; state_in = S_FRD;
               end
            end
         end
         S_SCAN: begin
            cmd.op = wfha_pkg::OP_SCAN_CMP;
            if (sts.scan_last) state_in = S_ALLOC;
         end
         S_ALLOC: begin
            if (sts.found) begin
               cmd.op = wfha_pkg::OP_ALLOC_WR; state_in = S_SPLIT;
            end else begin
               rv_in = 1'b1; st_in = wfha_pkg::ST_NOFIT; si_in = '0; state_in = S_IDLE;
            end
         end
         S_SPLIT: begin
            if (sts.has_rest) begin
               cmd.op = wfha_pkg::OP_SPLIT_WR; state_in = S_SNRD;
            end else begin
               rv_in = 1'b1; st_in = wfha_pkg::ST_DONE; si_in = best_index;
               state_in = S_IDLE;
            end
         end
         S_SNRD: begin
            cmd.op = wfha_pkg::OP_SPLIT_NXT_RD; state_in = S_SNWR;
         end
         S_SNWR: begin
            if (sts.has_link) cmd.op = wfha_pkg::OP_SPLIT_NXT_WR;
            state_in = S_IDLE;
            rv_in = 1'b1; st_in = wfha_pkg::ST_DONE; si_in = best_index;
         end
         S_FRD: begin
            fnz_in = sts.cur_nz;
            if (!sts.is_start) begin
               rv_in = 1'b1; st_in = wfha_pkg::ST_IGNORED; si_in = '0; state_in = S_IDLE;
            end else begin
               cmd.op = wfha_pkg::OP_FREE_NXT_RD; state_in = S_FNXT;
            end
         end
         S_FNXT: begin
            if (sts.nxt_free) begin
               cmd.op = wfha_pkg::OP_FREE_NXT_WR; state_in = S_FNWR;
            end else begin
               cmd.op = wfha_pkg::OP_FREE_LINK_RD; state_in = S_FLRD; fp_in = 1'b1;
            end
         end
         S_FNWR: begin
            cmd.op = wfha_pkg::OP_FREE_LINK_RD; state_in = S_FLRD; fp_in = 1'b1;
         end
         S_FLRD: begin
            if (sts.has_link) begin
               cmd.op = wfha_pkg::OP_FREE_LINK_WR; state_in = S_FLWR;
            end else state_in = S_FLWR;
         end
         S_FLWR: begin
            if (fp_ff && fnz_ff) begin
               cmd.op = wfha_pkg::OP_FREE_PRV_RD; state_in = S_FPRD;
            end else state_in = S_FDONE;
         end
         S_FPRD: begin
            if (sts.prv_free) begin
               cmd.op = wfha_pkg::OP_FREE_PRV_WR; state_in = S_FPWR;
            end else state_in = S_FDONE;
         end
         S_FPWR: begin
            fp_in = 1'b0;
            cmd.op = wfha_pkg::OP_FREE_LINK_RD; state_in = S_FLRD;
         end
         S_FCHK: state_in = S_FDONE;
         S_FDONE: begin
            fp_in = 1'b0;
            rv_in = 1'b1; st_in = wfha_pkg::ST_DONE; si_in = '0; state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         rv_ff <= 1'b0;
         fp_ff <= 1'b0;
         fnz_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rv_ff <= rv_in;
         fp_ff <= fp_in;
         fnz_ff <= fnz_in;
      end
      st_ff <= st_in;
      si_ff <= si_in;
   end

   `WFH_ASSERT_IMPL(a_no_take_busy, clock, reset,
      state_ff != S_IDLE, !req_take, "transaction taken while busy")
   `WFH_ASSERT_NEXT(a_rsp_hold, clock, reset,
      rv_ff && rsp_stall, rv_ff && $stable(st_ff) && $stable(si_ff),
      "stalled response changed")
   `WFH_ASSERT_IMPL(a_status_code, clock, reset,
      rv_ff, st_ff == wfha_pkg::ST_DONE || st_ff == wfha_pkg::ST_NOFIT ||
      st_ff == wfha_pkg::ST_IGNORED, "bad status code")
endmodule

FILE: rtl/core/worst_fit_heap_allocator_unit.sv
// Top level of the worst-fit heap allocator.
// Usage:
//  req channel: req_valid/req_stall carry one transaction with req_kind
//  (0 allocate, 1 free), req_alloc_size and req_free_index.
//  rsp channel: rsp_valid/rsp_stall return rsp_status and rsp_start_index,
//  one response per request, in order.
//  An allocate walks every table entry through one memory read port; a
//  free does not, and a zero-size allocate answers without a scan.
//  After reset a clearing pass writes every entry of the segment table
//  (one free segment spanning the heap); req_stall is high during it.
//  One transaction is in flight at a time; req_stall stays high while it
//  runs and while its response waits under rsp_stall.
module worst_fit_heap_allocator_unit (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic       req_kind,
   input  logic [10:0] req_alloc_size,
   input  logic [9:0] req_free_index,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [1:0] rsp_status,
   output logic [9:0] rsp_start_index
);
   wfha_pkg::cmd_type cmd;
   wfha_pkg::sts_type sts;
   logic [9:0] best_index;

   wfha_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_stall, .req_kind, .req_alloc_size,
      .rsp_valid, .rsp_stall, .rsp_status, .rsp_start_index,
      .best_index, .sts, .cmd
   );

   wfha_datapath u_dp (
      .clock, .reset, .cmd, .req_alloc_size, .req_free_index, .sts, .best_index
   );
endmodule
